/* rtl/ile_pkg.sv */
// ---------------------------------------------------------------------------
// ile_pkg
// shared types and codes of the indexed list engine
// ---------------------------------------------------------------------------
package ile_pkg;

    // largest list the cell row is built for, sets the width of cell indexes
    localparam int MAX_CAPACITY = 64;
    localparam int CELL_IDX_W   = $clog2(MAX_CAPACITY);

    // at most this many words are streamed by one dump
    localparam int MAX_RESULTS  = 16;

    localparam int WORD_W       = 32;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND     = 3'd0,
        MODE_INSERT     = 3'd1,
        MODE_DEL_LAST   = 3'd2,
        MODE_DEL_AT     = 3'd3,
        MODE_DEL_VALUE  = 3'd4,
        MODE_DUMP       = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_RANGE      = 3'd1,
        STAT_NOTFOUND   = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_EMPTY      = 3'd4
    } t_status;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_LOAD       = 3'd1,   // cell at index takes the input word
        CELL_OPEN       = 3'd2,   // cells above index take left, index takes input
        CELL_CLOSE      = 3'd3,   // cells at and above index take right
        CELL_CLOSE_MASK = 3'd4,   // cells with their mask bit set take right
        CELL_ROTATE     = 3'd5,   // cells below index take right, index takes head
        CELL_SEARCH     = 3'd6    // every cell registers its compare result
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [CELL_IDX_W-1:0] at;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_DUMP   = 2'd2
    } t_state;

endpackage

/* rtl/ile_cell.sv */
// ---------------------------------------------------------------------------
// ile_cell
// one list slot: holds a word, moves it to or from its neighbors
// ---------------------------------------------------------------------------
module ile_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  ile_pkg::t_cell_cmd          i_cmd,
    input  logic                        i_close,
    input  logic [ile_pkg::WORD_W-1:0]  i_value,
    input  logic [ile_pkg::WORD_W-1:0]  i_left,
    input  logic [ile_pkg::WORD_W-1:0]  i_right,
    input  logic [ile_pkg::WORD_W-1:0]  i_head,
    output logic [ile_pkg::WORD_W-1:0]  o_data,
    output logic                        o_hit
);

    logic [ile_pkg::WORD_W-1:0] r_data;
    logic [ile_pkg::WORD_W-1:0] n_data;
    logic                       r_hit;
    logic                       n_hit;
    logic                       w_eq;
    logic                       w_above;

    assign w_eq    = (int'(i_cmd.at) == IDX);
    assign w_above = (int'(i_cmd.at) < IDX);

    always_comb begin
        n_data = r_data;
        n_hit  = r_hit;
        case (i_cmd.op)
            ile_pkg::CELL_LOAD: begin
                if (w_eq) n_data = i_value;
            end
            ile_pkg::CELL_OPEN: begin
                if (w_eq) n_data = i_value;
                else if (w_above) n_data = i_left;
            end
            ile_pkg::CELL_CLOSE: begin
                if (w_eq || w_above) n_data = i_right;
            end
            ile_pkg::CELL_CLOSE_MASK: begin
                if (i_close) n_data = i_right;
            end
            ile_pkg::CELL_ROTATE: begin
                if (w_eq) n_data = i_head;
                else if (!w_above) n_data = i_right;
            end
            ile_pkg::CELL_SEARCH: begin
                n_hit = (r_data == i_value);
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

/* rtl/indexed_list_engine_unit.sv */
// ---------------------------------------------------------------------------
// indexed_list_engine_unit
// ordered list of signed words kept in a shifting row of cells
// ---------------------------------------------------------------------------
// usage:
//   input channel i_valid / o_stall carries one command word: mode, position
//   and value. output channel o_valid / i_stall carries result words: status,
//   element, count and last. a word moves at an edge with valid high and
//   stall low.
//   append, insert, delete last and delete at position finish in the accept
//   cycle: the status word is loaded into the output register, and the next
//   command follows back to back unless the receiver stalls the output.
//   delete value takes two steps: the cells compare in the first, the first
//   hit is picked and the row closes the gap in the second.
//   dump runs the accept cycle, then one rotation of the row per element; up
//   to 16 words are streamed head first, one per cycle while the receiver
//   keeps up, last set on the final one. an empty list gives one status
//   word instead.
//   unused modes are taken and dropped with no result.
//   o_stall is high while an operation is in flight and while the output
//   register holds a word that the receiver stalls.
//   reset empties the list (fill goes to zero) and drops any pending word;
//   the cell contents are left as they are and never read before written.
// ---------------------------------------------------------------------------
module indexed_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ile_pkg::MODE_W-1:0]    i_mode,
    input  logic [ile_pkg::POS_W-1:0]     i_position,
    input  logic signed [ile_pkg::WORD_W-1:0] i_value,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ile_pkg::STATUS_W-1:0]  o_status,
    output logic signed [ile_pkg::WORD_W-1:0] o_element,
    output logic [ile_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_last
);

    // fill must be able to hold CAPACITY itself
    localparam int FW = $clog2(CAPACITY + 1);

    // control state
    ile_pkg::t_state r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_cnt, n_cnt;

    // output register
    logic                             r_ov;
    logic [ile_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [ile_pkg::WORD_W-1:0]       r_elem, n_elem;
    logic [ile_pkg::COUNT_W-1:0]      r_count, n_count;
    logic                             r_last, n_last;
    logic                             w_out_ld;

    // cell row
    ile_pkg::t_cell_cmd               w_cmd;
    logic [ile_pkg::WORD_W-1:0]       w_data [CAPACITY];
    logic [CAPACITY-1:0]              w_hit;
    logic [CAPACITY-1:0]              w_fill_mask;
    logic [CAPACITY-1:0]              w_match;
    logic [CAPACITY-1:0]              w_first;
    logic [CAPACITY-1:0]              w_close;

    logic                             w_accept;
    logic                             w_slot_ok;
    logic                             w_in_range;
    logic                             w_full;
    logic                             w_empty;
    logic                             w_emit_more;
    logic                             w_emit_last;
    logic                             w_dump_done;

    // output slot is free this cycle if empty or being taken
    assign w_slot_ok = !r_ov || !i_stall;
    assign o_stall   = !((r_state == ile_pkg::ST_IDLE) && w_slot_ok);
    assign w_accept  = i_valid && !o_stall;

    assign w_in_range = int'(i_position) < int'(r_fill);
    assign w_full     = int'(r_fill) >= CAPACITY;
    assign w_empty    = (r_fill == '0);

    // first hit among the valid cells, and every cell at or above it
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_fill_mask[i] = (i < int'(r_fill));
        end
    end
    assign w_match = w_hit & w_fill_mask;
    assign w_first = w_match & (~w_match + CAPACITY'(1));
    assign w_close = ~(w_first - CAPACITY'(1));

    // dump bookkeeping: r_cnt is the element now at the head
    assign w_emit_more = (int'(r_cnt) < ile_pkg::MAX_RESULTS);
    assign w_emit_last = ((int'(r_cnt) + 1) == int'(r_fill))
                      || ((int'(r_cnt) + 1) == ile_pkg::MAX_RESULTS);
    assign w_dump_done = ((int'(r_cnt) + 1) == int'(r_fill));

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        w_cmd.op  = ile_pkg::CELL_HOLD;
        w_cmd.at  = '0;
        w_out_ld  = 1'b0;
        n_status  = ile_pkg::STAT_OK;
        n_elem    = '0;
        n_last    = 1'b1;
        case (r_state)
            ile_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (ile_pkg::t_mode'(i_mode))
                        ile_pkg::MODE_APPEND: begin
                            w_out_ld = 1'b1;
                            if (w_full) begin
                                n_status = ile_pkg::STAT_FULL;
                            end else begin
                                w_cmd.op = ile_pkg::CELL_LOAD;
                                w_cmd.at = ile_pkg::CELL_IDX_W'(r_fill);
                                n_fill   = r_fill + FW'(1);
                            end
                        end
                        ile_pkg::MODE_INSERT: begin
                            w_out_ld = 1'b1;
                            if (!w_in_range) begin
                                n_status = ile_pkg::STAT_RANGE;
                            end else if (w_full) begin
                                n_status = ile_pkg::STAT_FULL;
                            end else begin
                                w_cmd.op = ile_pkg::CELL_OPEN;
                                w_cmd.at = ile_pkg::CELL_IDX_W'(i_position);
                                n_fill   = r_fill + FW'(1);
                            end
                        end
                        ile_pkg::MODE_DEL_LAST: begin
                            w_out_ld = 1'b1;
                            if (w_empty) n_status = ile_pkg::STAT_EMPTY;
                            else n_fill = r_fill - FW'(1);
                        end
                        ile_pkg::MODE_DEL_AT: begin
                            w_out_ld = 1'b1;
                            if (w_empty) begin
                                n_status = ile_pkg::STAT_EMPTY;
                            end else if (!w_in_range) begin
                                n_status = ile_pkg::STAT_RANGE;
                            end else begin
                                w_cmd.op = ile_pkg::CELL_CLOSE;
                                w_cmd.at = ile_pkg::CELL_IDX_W'(i_position);
                                n_fill   = r_fill - FW'(1);
                            end
                        end
                        ile_pkg::MODE_DEL_VALUE: begin
                            if (w_empty) begin
                                w_out_ld = 1'b1;
                                n_status = ile_pkg::STAT_EMPTY;
                            end else begin
                                // cells compare now, gap closes next cycle
                                w_cmd.op = ile_pkg::CELL_SEARCH;
                                n_state  = ile_pkg::ST_SEARCH;
                            end
                        end
                        ile_pkg::MODE_DUMP: begin
                            if (w_empty) begin
                                w_out_ld = 1'b1;
                                n_status = ile_pkg::STAT_EMPTY;
                            end else begin
                                n_cnt   = '0;
                                n_state = ile_pkg::ST_DUMP;
                            end
                        end
                        default: begin
                            // unused mode, dropped
                            n_state = ile_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ile_pkg::ST_SEARCH: begin
                // output slot is known free here
                w_out_ld = 1'b1;
                n_state  = ile_pkg::ST_IDLE;
                if (w_match == '0) begin
                    n_status = ile_pkg::STAT_NOTFOUND;
                end else begin
                    w_cmd.op = ile_pkg::CELL_CLOSE_MASK;
                    n_fill   = r_fill - FW'(1);
                end
            end
            ile_pkg::ST_DUMP: begin
                // rotate the valid part of the row by one; words past the
                // stream limit still rotate so the order comes back intact
                if (!w_emit_more || w_slot_ok) begin
                    w_cmd.op = ile_pkg::CELL_ROTATE;
                    w_cmd.at = ile_pkg::CELL_IDX_W'(r_fill - FW'(1));
                    n_cnt    = r_cnt + FW'(1);
                    if (w_emit_more) begin
                        w_out_ld = 1'b1;
                        n_elem   = w_data[0];
                        n_last   = w_emit_last;
                    end
                    if (w_dump_done) n_state = ile_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ile_pkg::ST_IDLE;
            end
        endcase
        n_count = ile_pkg::COUNT_W'(n_fill);
    end

    // cell row, each cell wired to its two neighbors and the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ile_pkg::WORD_W-1:0] w_left;
        logic [ile_pkg::WORD_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        ile_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_close (w_close[g]),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::ST_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            if (w_out_ld) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_status <= n_status;
            r_elem   <= n_elem;
            r_count  <= n_count;
            r_last   <= n_last;
        end
    end

    assign o_valid   = r_ov;
    assign o_status  = r_status;
    assign o_element = r_elem;
    assign o_count   = r_count;
    assign o_last    = r_last;

    // fill never runs past the row
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= CAPACITY)
        else $error("fill beyond capacity");

    // a new word is never loaded over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |-> !w_out_ld)
        else $error("output word overwritten");

    // the search step always finds the output slot free
    a_search_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ile_pkg::ST_SEARCH) |-> !r_ov)
        else $error("output busy in search step");

    // fill moves by at most one per cycle
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + FW'(1))
                  || (r_fill == $past(r_fill) - FW'(1))))
        else $error("fill jumped");

    // no command is taken while an operation is in flight
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ile_pkg::ST_IDLE) |-> o_stall)
        else $error("command taken while busy");

endmodule

/* dv/indexed_list_engine_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// indexed_list_engine_unit_tb
// self-checking bench: a scoreboard keeps its own copy of the list, predicts
// the result words of every accepted command and checks them in order while
// both channels idle and stall at random
// ---------------------------------------------------------------------------
module indexed_list_engine_unit_tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 205;
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int HOLD_AT_WORD = 50;   // word count that starts the hold-off
    localparam int DRAIN_CYCLES = 40;   // longer than a full dump

    localparam logic signed [ile_pkg::WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [ile_pkg::WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
    localparam logic signed [ile_pkg::WORD_W-1:0] WORD_ONES = 32'shffff_ffff;
    // command codes the block must drop without a result
    localparam logic [ile_pkg::MODE_W-1:0] MODE_SPARE_A = ile_pkg::MODE_DUMP + 3'd1;
    localparam logic [ile_pkg::MODE_W-1:0] MODE_SPARE_B = ile_pkg::MODE_DUMP + 3'd2;

    typedef struct {
        ile_pkg::t_status                  status;
        logic signed [ile_pkg::WORD_W-1:0] element;
        logic [ile_pkg::COUNT_W-1:0]       count;
        logic                              last;
    } t_result_word;

    // -----------------------------------------------------------------------
    // scoreboard: list copy, predicted result words, in-order compare
    // -----------------------------------------------------------------------
    class list_scoreboard;
        logic signed [ile_pkg::WORD_W-1:0] cells [CAPACITY];
        int                                fill = 0;
        t_result_word                      due_words [$];
        int                                mismatches = 0;

        function void push_word(ile_pkg::t_status st,
                                logic signed [ile_pkg::WORD_W-1:0] elem, logic fin);
            t_result_word w;
            w.status  = st;
            w.element = elem;
            w.count   = fill[ile_pkg::COUNT_W-1:0];
            w.last    = fin;
            due_words.push_back(w);
        endfunction

        // close the gap left by the element at index at
        function void remove_at(int at);
            for (int i = at; i + 1 < fill; i++)
                cells[i] = cells[i + 1];
            fill--;
        endfunction

        function void note_command(logic [ile_pkg::MODE_W-1:0] mode,
                                   logic [ile_pkg::POS_W-1:0] pos,
                                   logic signed [ile_pkg::WORD_W-1:0] val);
            int               at;
            int               n;
            int               hit;
            ile_pkg::t_status st;
            at  = int'(pos);
            st  = ile_pkg::STAT_OK;
            hit = -1;
            case (mode)
                ile_pkg::MODE_APPEND: begin
                    if (fill >= CAPACITY) begin
                        st = ile_pkg::STAT_FULL;
                    end else begin
                        cells[fill] = val;
                        fill++;
                    end
                    push_word(st, '0, 1'b1);
                end
                ile_pkg::MODE_INSERT: begin
                    if (at >= fill) begin
                        st = ile_pkg::STAT_RANGE;
                    end else if (fill >= CAPACITY) begin
                        st = ile_pkg::STAT_FULL;
                    end else begin
                        for (int i = fill; i > at; i--)
                            cells[i] = cells[i - 1];
                        cells[at] = val;
                        fill++;
                    end
                    push_word(st, '0, 1'b1);
                end
                ile_pkg::MODE_DEL_LAST: begin
                    if (fill == 0)
                        st = ile_pkg::STAT_EMPTY;
                    else
                        fill--;
                    push_word(st, '0, 1'b1);
                end
                ile_pkg::MODE_DEL_AT: begin
                    if (fill == 0)
                        st = ile_pkg::STAT_EMPTY;
                    else if (at >= fill)
                        st = ile_pkg::STAT_RANGE;
                    else
                        remove_at(at);
                    push_word(st, '0, 1'b1);
                end
                ile_pkg::MODE_DEL_VALUE: begin
                    if (fill == 0) begin
                        st = ile_pkg::STAT_EMPTY;
                    end else begin
                        // only the first match from the head goes
                        for (int i = 0; i < fill && hit < 0; i++)
                            if (cells[i] == val)
                                hit = i;
                        if (hit < 0)
                            st = ile_pkg::STAT_NOTFOUND;
                        else
                            remove_at(hit);
                    end
                    push_word(st, '0, 1'b1);
                end
                ile_pkg::MODE_DUMP: begin
                    if (fill == 0) begin
                        push_word(ile_pkg::STAT_EMPTY, '0, 1'b1);
                    end else begin
                        n = (fill < ile_pkg::MAX_RESULTS) ? fill : ile_pkg::MAX_RESULTS;
                        for (int i = 0; i < n; i++)
                            push_word(ile_pkg::STAT_OK, cells[i], i + 1 == n);
                    end
                end
                default: ;  // spare codes are dropped
            endcase
        endfunction

        function void check_word(logic [ile_pkg::STATUS_W-1:0] status,
                                 logic signed [ile_pkg::WORD_W-1:0] element,
                                 logic [ile_pkg::COUNT_W-1:0] count, logic last);
            t_result_word w;
            if (due_words.size() == 0) begin
                $error("result word with nothing due: status %0d element %0d count %0d last %0d",
                       status, element, count, last);
                mismatches++;
                return;
            end
            w = due_words.pop_front();
            if (status !== w.status) begin
                $error("status mismatch: expected %0d, actual %0d", w.status, status);
                mismatches++;
            end
            if (element !== w.element) begin
                $error("element mismatch: expected %0d, actual %0d", w.element, element);
                mismatches++;
            end
            if (count !== w.count) begin
                $error("count mismatch: expected %0d, actual %0d", w.count, count);
                mismatches++;
            end
            if (last !== w.last) begin
                $error("last mismatch: expected %0d, actual %0d", w.last, last);
                mismatches++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // block under test
    // -----------------------------------------------------------------------
    logic                              i_clk;
    logic                              i_rst_n    = 1'b0;
    logic                              i_valid    = 1'b0;
    logic                              o_stall;
    logic [ile_pkg::MODE_W-1:0]        i_mode     = '0;
    logic [ile_pkg::POS_W-1:0]         i_position = '0;
    logic signed [ile_pkg::WORD_W-1:0] i_value    = '0;
    logic                              o_valid;
    logic                              i_stall    = 1'b0;
    logic [ile_pkg::STATUS_W-1:0]      o_status;
    logic signed [ile_pkg::WORD_W-1:0] o_element;
    logic [ile_pkg::COUNT_W-1:0]       o_count;
    logic                              o_last;

    indexed_list_engine_unit #(.CAPACITY(CAPACITY)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_count    (o_count),
        .o_last     (o_last)
    );

    list_scoreboard sb;

    // set by the receiver during its long hold-off, the sender then offers back to back
    bit hold_off;
    // sender stretch with no idle cycles
    bit eager;
    int words_seen;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // every accepted result word goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_status, o_element, o_count, o_last);
    end

    // -----------------------------------------------------------------------
    // command side: idle gap, offer the word, hold it until accepted
    // -----------------------------------------------------------------------
    task automatic send_command(logic [ile_pkg::MODE_W-1:0] mode,
                                logic [ile_pkg::POS_W-1:0] pos,
                                logic signed [ile_pkg::WORD_W-1:0] val);
        int gap;
        gap = (hold_off || eager) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(mode, pos, val);
    endtask

    // -----------------------------------------------------------------------
    // result side: random stall before each word, one long hold-off so the
    // output register fills and the block stalls its command side
    // -----------------------------------------------------------------------
    initial begin
        int  wait_cycles;
        bit  held;
        bit  steady;
        held       = 1'b0;
        steady     = 1'b0;
        hold_off   = 1'b0;
        words_seen = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            if (!held && words_seen >= HOLD_AT_WORD) begin
                held     = 1'b1;
                hold_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                wait_cycles = steady ? 0 : $urandom_range(0, 15);
                if (wait_cycles > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            words_seen++;
        end
    end

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin
        int                                items;
        int                                roll;
        bit                                growing;
        logic [ile_pkg::MODE_W-1:0]        mode;
        logic [ile_pkg::POS_W-1:0]         pos;
        logic signed [ile_pkg::WORD_W-1:0] val;

        sb      = new();
        eager   = 1'b0;
        growing = 1'b1;
        items   = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every operation on the empty list
        send_command(ile_pkg::MODE_DUMP, '0, '0);
        send_command(ile_pkg::MODE_DEL_LAST, '0, '0);
        send_command(ile_pkg::MODE_DEL_AT, '0, '0);
        send_command(ile_pkg::MODE_DEL_VALUE, '0, WORD_ONES);
        send_command(ile_pkg::MODE_INSERT, '0, 32'sd9);      // insert into empty: out of range
        // extremes of the word
        send_command(ile_pkg::MODE_APPEND, '0, WORD_MIN);
        send_command(ile_pkg::MODE_APPEND, '0, WORD_MAX);
        send_command(ile_pkg::MODE_APPEND, '0, '0);
        send_command(ile_pkg::MODE_APPEND, '0, WORD_ONES);
        send_command(ile_pkg::MODE_INSERT, 5'd0, 32'sd5);    // new head
        send_command(ile_pkg::MODE_INSERT, 5'd4, 32'sd77);   // before the last element
        send_command(ile_pkg::MODE_INSERT, 5'd6, 32'sd1);    // past the end
        send_command(ile_pkg::MODE_INSERT, 5'd31, 32'sd1);
        send_command(ile_pkg::MODE_DEL_AT, 5'd31, '0);
        send_command(ile_pkg::MODE_DEL_VALUE, '0, 32'sd5);   // match at the head
        send_command(ile_pkg::MODE_DEL_VALUE, '0, 32'sd1234); // no match
        send_command(ile_pkg::MODE_APPEND, '0, '0);          // duplicate, first copy goes
        send_command(ile_pkg::MODE_DEL_VALUE, '0, '0);
        send_command(MODE_SPARE_A, 5'd31, WORD_ONES);
        send_command(MODE_SPARE_B, 5'd0, WORD_MIN);
        send_command(ile_pkg::MODE_DUMP, '0, '0);
        send_command(ile_pkg::MODE_DEL_AT, 5'd0, '0);
        send_command(ile_pkg::MODE_DEL_AT, 5'(sb.fill - 1), '0);
        send_command(ile_pkg::MODE_DEL_LAST, '0, '0);
        send_command(ile_pkg::MODE_DUMP, '0, '0);

        // random: grow and shrink phases walk the list between empty and full
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 24) == 0)
                eager = !eager;
            if (growing && sb.fill == CAPACITY && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            else if (!growing && sb.fill == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 29) == 0)
                growing = !growing;

            roll = $urandom_range(0, 99);
            if (roll < 3)
                mode = ile_pkg::MODE_DUMP + 3'($urandom_range(1, 2));
            else if (growing)
                mode = (roll < 38) ? ile_pkg::MODE_APPEND   :
                       (roll < 63) ? ile_pkg::MODE_INSERT   :
                       (roll < 73) ? ile_pkg::MODE_DUMP     :
                       (roll < 78) ? ile_pkg::MODE_DEL_LAST :
                       (roll < 88) ? ile_pkg::MODE_DEL_AT   : ile_pkg::MODE_DEL_VALUE;
            else
                mode = (roll < 11) ? ile_pkg::MODE_APPEND   :
                       (roll < 18) ? ile_pkg::MODE_INSERT   :
                       (roll < 28) ? ile_pkg::MODE_DUMP     :
                       (roll < 48) ? ile_pkg::MODE_DEL_LAST :
                       (roll < 73) ? ile_pkg::MODE_DEL_AT   : ile_pkg::MODE_DEL_VALUE;

            // values: stored words for delete hits, small ones for duplicates
            roll = $urandom_range(0, 7);
            if (roll < 2 && sb.fill > 0)
                val = sb.cells[$urandom_range(0, sb.fill - 1)];
            else if (roll < 4)
                val = $signed($urandom_range(0, 7)) - 4;
            else if (roll == 4)
                case ($urandom_range(0, 3))
                    0:       val = WORD_MIN;
                    1:       val = WORD_MAX;
                    2:       val = '0;
                    default: val = WORD_ONES;
                endcase
            else
                val = $urandom;

            // positions: mostly in range, some just past the end, some anywhere
            roll = $urandom_range(0, 7);
            if (roll == 0)
                pos = 5'($urandom_range(0, 31));
            else if (roll == 1)
                pos = 5'(sb.fill);
            else
                pos = (sb.fill > 0) ? 5'($urandom_range(0, sb.fill - 1)) : '0;

            send_command(mode, pos, val);
            if (mode <= ile_pkg::MODE_DUMP)
                items++;
        end

        // drain, then give the block time to show any stray word
        i_valid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.due_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
